// ----- hw/rtl/lps_pkg.sv -----
`default_nettype none

package lps_pkg;

    // Sizing
    localparam int MAX_LAGS    = 128;
    localparam int SAMPLE_BITS = 8;
    localparam int COUNT_BITS  = 20;

    localparam int IDX_BITS  = $clog2(MAX_LAGS);
    localparam int FILL_BITS = $clog2(MAX_LAGS + 1);

    // Port field widths
    localparam int SAMPLE_W = 8;
    localparam int CNT_W    = 20;
    localparam int LAG_W    = 8;
    localparam int CFG_W    = 8;

    localparam logic [CFG_W-1:0]      CFG_RESET = CFG_W'(128);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    // Item passed from front to back
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   first;
        logic [IDX_BITS-1:0]    d_last;
    } lps_item_t;

    // Back sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_HIT,
        ST_HITCHK,
        ST_WALK,
        ST_FINISH
    } lps_state_t;

    // Saturating increment
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == CNT_MAX) ? v : v + COUNT_BITS'(1);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lps_in_if.sv -----
`default_nettype none

interface lps_in_if;
    import lps_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                restart;

    modport source (output valid, output sample, output restart, input ready);
    modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lps_out_if.sv -----
`default_nettype none

interface lps_out_if;
    import lps_pkg::*;

    logic             valid;
    logic             ready;
    logic             correct;
    logic [CNT_W-1:0] correct_count;
    logic [CNT_W-1:0] longest_run;
    logic [LAG_W-1:0] winner_lag;

    modport source (output valid, output correct, output correct_count,
                    output longest_run, output winner_lag, input ready);
    modport sink   (input valid, input correct, input correct_count,
                    input longest_run, input winner_lag, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/lag_predictor_scoreboard.sv -----
// Flow: an item passes IDLE, HIT, HITCHK, a WALK over the D active lags and FINISH, which
// waits for the output; the first item of a sequence sweeps the score RAM in CLEAR instead.
// Throughput: the score RAM walk takes one lag per cycle, and the back side takes a new item
// only after the last; a two-entry queue lets the input side run ahead of the walk.
// Reset: asynchronous, active low; clears control state and sets active_lags to 128.
`default_nettype none

module lag_predictor_scoreboard (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    lps_in_if.sink                         samples,
    lps_out_if.source                      results,
    input  wire logic                      cfg_we,
    input  wire logic [lps_pkg::CFG_W-1:0] cfg_wdata
);
    import lps_pkg::*;

    logic [CFG_W-1:0] active_lags_reg, active_lags_next;
    logic             q_valid;
    lps_item_t        q_item;
    logic             q_pop;

    // Lag count register
    assign active_lags_next = cfg_we ? cfg_wdata : active_lags_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_lags_reg <= CFG_RESET;
        end
        else
        begin
            active_lags_reg <= active_lags_next;
        end
    end

    lps_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples),
        .active_lags (active_lags_reg),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    lps_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .results (results)
    );
endmodule

`default_nettype wire

// ----- hw/rtl/lps_ram.sv -----
`default_nettype none

module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int ABITS = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [ABITS-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [ABITS-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

// ----- hw/rtl/lps_front.sv -----
`default_nettype none

module lps_front (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    lps_in_if.sink                        samples,
    input  wire logic [lps_pkg::CFG_W-1:0] active_lags,
    output logic                          q_valid,
    output lps_pkg::lps_item_t            q_item,
    input  wire logic                     q_pop
);
    import lps_pkg::*;

    lps_item_t        mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             seen_reg, seen_next;
    logic             push;
    logic             pop;
    lps_item_t        new_item;
    logic [IDX_BITS-1:0] d_last;

    // Clamp the lag count to 1..MAX_LAGS, kept as last lag index
    always_comb
    begin
        if (active_lags == '0)
        begin
            d_last = '0;
        end
        else if (int'(active_lags) > MAX_LAGS)
        begin
            d_last = IDX_BITS'(MAX_LAGS - 1);
        end
        else
        begin
            d_last = IDX_BITS'(active_lags - CFG_W'(1));
        end
    end

    // Classify: an item opens a sequence on restart or before any item
    assign new_item.sample = samples.sample[SAMPLE_BITS-1:0];
    assign new_item.first  = samples.restart || !seen_reg;
    assign new_item.d_last = d_last;

    assign samples.ready = (count_reg != 2'd2);
    assign push          = samples.valid && samples.ready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_item        = mem_reg[rd_ptr_reg];
    assign pop           = q_pop && q_valid;

    // Two-entry queue pointers
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
        seen_next   = seen_reg || push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            seen_reg   <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            seen_reg   <= seen_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end
endmodule

`default_nettype wire

// ----- hw/rtl/lps_back.sv -----
`default_nettype none

module lps_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire lps_pkg::lps_item_t q_item,
    output logic                    q_pop,
    lps_out_if.source               results
);
    import lps_pkg::*;

    lps_state_t             state_reg, state_next;
    logic [IDX_BITS-1:0]    cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]    head_reg, head_next;
    logic [FILL_BITS-1:0]   fill_reg, fill_next;
    logic [IDX_BITS-1:0]    w_reg, w_next;
    logic [COUNT_BITS-1:0]  win_score_reg, win_score_next;
    logic [COUNT_BITS-1:0]  hits_reg, hits_next;
    logic [COUNT_BITS-1:0]  run_reg, run_next;
    logic [COUNT_BITS-1:0]  best_reg, best_next;
    logic                   hit_reg, hit_next;
    logic [SAMPLE_BITS-1:0] sample_reg, sample_next;
    logic [IDX_BITS-1:0]    d_last_reg, d_last_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;

    // RAM ports
    logic                   val_we;
    logic [IDX_BITS-1:0]    val_waddr, val_raddr;
    logic [SAMPLE_BITS-1:0] val_rdata;
    logic                   score_we;
    logic [IDX_BITS-1:0]    score_waddr, score_raddr;
    logic [COUNT_BITS-1:0]  score_wdata, score_rdata;

    logic [IDX_BITS-1:0]    rd_idx;
    logic                   out_free;
    logic                   hit_now;
    logic                   match;
    logic [COUNT_BITS-1:0]  score_inc;
    logic [COUNT_BITS-1:0]  run_inc;

    // Lag line as a circular buffer: lag d lives at head - d
    lps_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LAGS)) u_values (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (sample_reg),
        .raddr (val_raddr),
        .rdata (val_rdata)
    );

    // Score per lag
    lps_ram #(.WIDTH(COUNT_BITS), .DEPTH(MAX_LAGS)) u_scores (
        .clk   (clk),
        .we    (score_we),
        .waddr (score_waddr),
        .wdata (score_wdata),
        .raddr (score_raddr),
        .rdata (score_rdata)
    );

    assign out_free  = !out_valid_reg || results.ready;
    assign hit_now   = ({1'b0, w_reg} < fill_reg) && (val_rdata == sample_reg);
    assign match     = ({1'b0, cnt_reg} < fill_reg) && (val_rdata == sample_reg);
    assign score_inc = sat_inc(score_rdata);
    assign run_inc   = sat_inc(run_reg);

    // Read addresses: winner lag first, then the walk one lag ahead
    always_comb
    begin
        rd_idx      = (state_reg == ST_WALK) ? cnt_reg + IDX_BITS'(1) : '0;
        score_raddr = rd_idx;
        val_raddr   = (state_reg == ST_HIT) ? head_reg - w_reg : head_reg - rd_idx;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        w_next         = w_reg;
        win_score_next = win_score_reg;
        hits_next      = hits_reg;
        run_next       = run_reg;
        best_next      = best_reg;
        hit_next       = hit_reg;
        sample_next    = sample_reg;
        d_last_next    = d_last_reg;
        q_pop          = 1'b0;
        val_we         = 1'b0;
        val_waddr      = head_reg + IDX_BITS'(1);
        score_we       = 1'b0;
        score_waddr    = cnt_reg;
        score_wdata    = '0;
        out_load       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    sample_next = q_item.sample;
                    d_last_next = q_item.d_last;
                    cnt_next    = '0;
                    if (q_item.first)
                    begin
                        // New sequence: clear everything, then sweep the scores
                        w_next         = '0;
                        win_score_next = '0;
                        hits_next      = '0;
                        run_next       = '0;
                        best_next      = '0;
                        fill_next      = '0;
                        state_next     = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_HIT;
                    end
                end
            end

            ST_CLEAR:
            begin
                score_we = 1'b1;
                if (cnt_reg == IDX_BITS'(MAX_LAGS - 1))
                begin
                    val_we     = 1'b1;
                    head_next  = head_reg + IDX_BITS'(1);
                    fill_next  = FILL_BITS'(1);
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_BITS'(1);
                end
            end

            ST_HIT:
            begin
                state_next = ST_HITCHK;
            end

            ST_HITCHK:
            begin
                // Winner's stored value is on the read port now
                hit_next = hit_now;
                if (hit_now)
                begin
                    hits_next = sat_inc(hits_reg);
                    run_next  = run_inc;
                    if (run_inc > best_reg)
                    begin
                        best_next = run_inc;
                    end
                end
                else
                begin
                    run_next = '0;
                end
                cnt_next   = '0;
                state_next = ST_WALK;
            end

            ST_WALK:
            begin
                // Score lag cnt, winner follows ties toward higher lags
                if (match)
                begin
                    score_we    = 1'b1;
                    score_wdata = score_inc;
                    if ((cnt_reg == w_reg) || (win_score_reg <= score_inc))
                    begin
                        w_next         = cnt_reg;
                        win_score_next = score_inc;
                    end
                end
                if (cnt_reg == d_last_reg)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_BITS'(1);
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    val_we     = 1'b1;
                    head_next  = head_reg + IDX_BITS'(1);
                    if (int'(fill_reg) < MAX_LAGS)
                    begin
                        fill_next = fill_reg + FILL_BITS'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            w_reg         <= '0;
            win_score_reg <= '0;
            hits_reg      <= '0;
            run_reg       <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            w_reg         <= w_next;
            win_score_reg <= win_score_next;
            hits_reg      <= hits_next;
            run_reg       <= run_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        sample_reg <= sample_next;
        d_last_reg <= d_last_next;
        if (out_load)
        begin
            results.correct       <= hit_reg;
            results.correct_count <= CNT_W'(hits_reg);
            results.longest_run   <= CNT_W'(best_reg);
            results.winner_lag    <= LAG_W'({1'b0, w_reg}) + LAG_W'(1);
        end
    end

    assign results.valid = out_valid_reg;
endmodule

`default_nettype wire
